// File: rtl/rabin_encrypt_decrypt_engine_core_assert.svh
// Assertion macros shared by the engine RTL.
`ifndef RABIN_ENCRYPT_DECRYPT_ENGINE_CORE_ASSERT_SVH
`define RABIN_ENCRYPT_DECRYPT_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rabin_ed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rabin_ed_pkg;

    localparam int VALUE_W        = 32;
    localparam int ROOT_W         = 32;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int PRIME_BITS_DEF = 16;
    localparam int ALU_TOP_W      = $clog2(VALUE_W);

    localparam logic [CFG_W-1:0] PRIME_P_RST = 16'd7;
    localparam logic [CFG_W-1:0] PRIME_Q_RST = 16'd11;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIME_P = 1'b0,
        REG_PRIME_Q = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ALU_MOD    = 1'b0,
        ALU_MULMOD = 1'b1
    } t_alu_op;

    // top is the index of the first (most significant) operand bit to scan
    typedef struct packed {
        logic                 start;
        t_alu_op              op;
        logic [ALU_TOP_W-1:0] top;
    } t_alu_req;

endpackage
`default_nettype wire

// File: rtl/rabin_ed_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rabin_ed_cfg_if
    import rabin_ed_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rabin_ed_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rabin_ed_in_if
    import rabin_ed_pkg::*;
();
    logic               valid;
    logic               ready;
    t_opcode            opcode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

// File: rtl/rabin_ed_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rabin_ed_out_if
    import rabin_ed_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;
    logic [ROOT_W-1:0] root_c;
    logic [ROOT_W-1:0] root_d;

    modport source (output valid, output root_a, output root_b, output root_c,
                    output root_d, input ready);
    modport sink   (input valid, input root_a, input root_b, input root_c,
                    input root_d, output ready);
endinterface
`default_nettype wire

// File: rtl/rabin_encrypt_decrypt_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rabin_encrypt_decrypt_engine_core_assert.svh"
// Channel   Dir  Payload                               Transaction
// i_cfg     in   index, data (prime_p=0, prime_q=1)    valid & ready, ready always high
// i_in      in   opcode, value                         valid & ready, ready only when idle
// o_out     out  root_a, root_b, root_c, root_d        valid & ready, held until taken
//
// One item at a time; all modular reductions and products run through one serial add-and-reduce unit.
// Encrypt: value mod n, then c*c mod n, NW = 2*PW.
// Decrypt: Euclid plus two exponentiations, one per prime.
// Synchronous active-low reset loads prime_p = 7, prime_q = 11; a stalled result holds.
module rabin_encrypt_decrypt_engine_core
    import rabin_ed_pkg::*;
#(
    parameter int PRIME_BITS = PRIME_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rabin_ed_cfg_if.sink    i_cfg,
    rabin_ed_in_if.sink     i_in,
    rabin_ed_out_if.source  o_out
);

    localparam int PW  = (PRIME_BITS < CFG_W) ? PRIME_BITS : CFG_W;
    localparam int NW  = 2 * PW;
    localparam int CW  = PW + 2;
    localparam int EIW = $clog2(PW);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CMOD    = 13'b0000000000010,
        S_ENC     = 13'b0000000000100,
        S_EU_CHK  = 13'b0000000001000,
        S_EU_DIV  = 13'b0000000010000,
        S_PW_BASE = 13'b0000000100000,
        S_PW_SQ   = 13'b0000001000000,
        S_PW_MUL  = 13'b0000010000000,
        S_SMOD    = 13'b0000100000000,
        S_CRT     = 13'b0001000000000,
        S_FIN     = 13'b0010000000000,
        S_NEG     = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_wait, n_wait;
    logic [1:0] r_sub, n_sub;
    logic   r_side, n_side;
    logic [EIW-1:0] r_eidx, n_eidx;

    logic [PW-1:0] r_p;
    logic [PW-1:0] r_q;
    logic [NW-1:0] r_n;

    t_opcode            r_op;
    logic [VALUE_W-1:0] r_val;
    logic [NW-1:0]      r_c;
    logic [PW-1:0]      r_a0, r_b0;
    logic signed [CW-1:0] r_a1, r_a2, r_b1, r_b2;
    logic [PW-1:0]      r_base, r_acc, r_u, r_v;
    logic [NW-1:0]      r_sp, r_tq, r_t1, r_t2;
    logic [NW-1:0]      r_ra, r_rb, r_rc, r_rd;

    t_alu_req           alu_req;
    logic [NW-1:0]      alu_a;
    logic [VALUE_W-1:0] alu_x;
    logic [NW-1:0]      alu_m;
    logic               alu_done;
    logic [NW-1:0]      alu_res;
    logic [PW-1:0]      alu_quo;

    logic          in_acc;
    logic          prime_zero;
    logic [PW-1:0] pm;
    logic [PW:0]   pm_inc;
    logic [PW-2:0] e_raw;
    logic [PW-1:0] e_full;
    logic          e_bit;
    logic          pw_adv;
    logic          alu_state;
    logic signed [CW-1:0] jb1, jb2;
    logic signed [CW-1:0] smod_sel;
    logic [CW-1:0] smod_abs;
    logic [NW-1:0] smod_fix;
    logic [NW:0]   fin_s;
    logic [NW-1:0] fin_m1, fin_m2;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign prime_zero  = (r_p == '0) || (r_q == '0);

    // exponent (pm+1)/4 of the side being worked on, zero taken as one
    assign pm     = r_side ? r_q : r_p;
    assign pm_inc = (PW+1)'(pm) + (PW+1)'(1);
    assign e_raw  = pm_inc[PW:2];
    assign e_full = (e_raw == '0) ? PW'(1) : PW'(e_raw);
    assign e_bit  = e_full[r_eidx];
    assign pw_adv = alu_done && ((r_state == S_PW_SQ && !e_bit) || r_state == S_PW_MUL);

    // Euclid coefficient update; true values fit CW bits, so truncation is exact
    assign jb1 = $signed({2'b00, alu_quo}) * r_b1;
    assign jb2 = $signed({2'b00, alu_quo}) * r_b2;

    assign smod_sel = r_sub[0] ? r_a2 : r_a1;
    assign smod_abs = smod_sel[CW-1] ? CW'(-smod_sel) : CW'(smod_sel);
    assign smod_fix = (smod_sel[CW-1] && alu_res != '0) ? r_n - alu_res : alu_res;

    assign fin_s  = {1'b0, r_t1} + {1'b0, r_t2};
    assign fin_m1 = (fin_s >= {1'b0, r_n}) ? NW'(fin_s - {1'b0, r_n}) : fin_s[NW-1:0];
    assign fin_m2 = r_t1 - r_t2 + ((r_t1 < r_t2) ? r_n : '0);

    assign alu_state = (r_state == S_CMOD) || (r_state == S_ENC) || (r_state == S_EU_DIV)
                       || (r_state == S_PW_BASE) || (r_state == S_PW_SQ)
                       || (r_state == S_PW_MUL) || (r_state == S_SMOD) || (r_state == S_CRT);

    always_comb begin
        alu_req.start = alu_state && !r_wait;
        alu_req.op    = ALU_MOD;
        alu_req.top   = ALU_TOP_W'(VALUE_W - 1);
        alu_a         = '0;
        alu_x         = r_val;
        alu_m         = r_n;
        unique case (r_state)
            S_ENC: begin
                alu_req.op  = ALU_MULMOD;
                alu_req.top = ALU_TOP_W'(NW - 1);
                alu_a       = r_c;
                alu_x       = VALUE_W'(r_c);
            end
            S_EU_DIV: begin
                alu_req.top = ALU_TOP_W'(PW - 1);
                alu_x       = VALUE_W'(r_a0);
                alu_m       = NW'(r_b0);
            end
            S_PW_BASE: begin
                alu_req.top = ALU_TOP_W'(NW - 1);
                alu_x       = VALUE_W'(r_c);
                alu_m       = NW'(pm);
            end
            S_PW_SQ, S_PW_MUL: begin
                alu_req.op  = ALU_MULMOD;
                alu_req.top = ALU_TOP_W'(PW - 1);
                alu_a       = NW'(r_acc);
                alu_x       = (r_state == S_PW_MUL) ? VALUE_W'(r_base) : VALUE_W'(r_acc);
                alu_m       = NW'(pm);
            end
            S_SMOD: begin
                alu_req.top = ALU_TOP_W'(CW - 1);
                alu_x       = VALUE_W'(smod_abs);
            end
            S_CRT: begin
                alu_req.op  = ALU_MULMOD;
                alu_req.top = r_sub[0] ? ALU_TOP_W'(PW - 1) : ALU_TOP_W'(NW - 1);
                case (r_sub)
                    2'd0: begin
                        alu_a = NW'(r_u);
                        alu_x = VALUE_W'(r_tq);
                    end
                    2'd1: begin
                        alu_a = r_t1;
                        alu_x = VALUE_W'(r_q);
                    end
                    2'd2: begin
                        alu_a = NW'(r_v);
                        alu_x = VALUE_W'(r_sp);
                    end
                    default: begin
                        alu_a = r_t2;
                        alu_x = VALUE_W'(r_p);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    rabin_ed_alu #(
        .NW(NW),
        .QW(PW)
    ) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .i_a    (alu_a),
        .i_x    (alu_x),
        .i_m    (alu_m),
        .o_done (alu_done),
        .o_res  (alu_res),
        .o_quo  (alu_quo)
    );

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        n_sub   = r_sub;
        n_side  = r_side;
        n_eidx  = r_eidx;
        if (alu_req.start) begin
            n_wait = 1'b1;
        end
        if (alu_done) begin
            n_wait = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = prime_zero ? S_OUT : S_CMOD;
                    n_side  = 1'b0;
                    n_sub   = 2'd0;
                end
            end
            S_CMOD: begin
                if (alu_done) begin
                    n_state = (r_op == OP_DECRYPT) ? S_EU_CHK : S_ENC;
                end
            end
            S_ENC: begin
                if (alu_done) begin
                    n_state = S_OUT;
                end
            end
            S_EU_CHK: begin
                n_state = (r_b0 == '0) ? S_PW_BASE : S_EU_DIV;
            end
            S_EU_DIV: begin
                if (alu_done) begin
                    n_state = S_EU_CHK;
                end
            end
            S_PW_BASE: begin
                if (alu_done) begin
                    n_state = S_PW_SQ;
                    n_eidx  = EIW'(PW - 1);
                end
            end
            S_PW_SQ: begin
                if (alu_done && e_bit) begin
                    n_state = S_PW_MUL;
                end
            end
            S_PW_MUL: begin
            end
            S_SMOD: begin
                if (alu_done) begin
                    if (r_sub == 2'd0) begin
                        n_sub = 2'd1;
                    end else begin
                        n_sub   = 2'd0;
                        n_state = S_CRT;
                    end
                end
            end
            S_CRT: begin
                if (alu_done) begin
                    n_sub = r_sub + 2'd1;
                    if (r_sub == 2'd3) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_state = S_NEG;
            end
            S_NEG: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // next exponent bit, or move on once both roots are done
        if (pw_adv) begin
            if (r_eidx == '0) begin
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = S_PW_BASE;
                end else begin
                    n_sub   = 2'd0;
                    n_state = S_SMOD;
                end
            end else begin
                n_eidx  = r_eidx - 1'b1;
                n_state = S_PW_SQ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_sub   <= 2'd0;
            r_side  <= 1'b0;
            r_eidx  <= '0;
            r_p     <= PRIME_P_RST[PW-1:0];
            r_q     <= PRIME_Q_RST[PW-1:0];
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_sub   <= n_sub;
            r_side  <= n_side;
            r_eidx  <= n_eidx;
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    REG_PRIME_P: r_p <= i_cfg.data[PW-1:0];
                    REG_PRIME_Q: r_q <= i_cfg.data[PW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= NW'(r_p) * NW'(r_q);
        if (in_acc) begin
            r_val <= i_in.value;
            r_op  <= i_in.opcode;
            r_a0  <= r_p;
            r_a1  <= CW'(1);
            r_a2  <= '0;
            r_b0  <= r_q;
            r_b1  <= '0;
            r_b2  <= CW'(1);
            r_ra  <= '0;
            r_rb  <= '0;
            r_rc  <= '0;
            r_rd  <= '0;
        end
        if (alu_done) begin
            case (r_state)
                S_CMOD: r_c  <= alu_res;
                S_ENC:  r_ra <= alu_res;
                S_EU_DIV: begin
                    r_a0 <= r_b0;
                    r_a1 <= r_b1;
                    r_a2 <= r_b2;
                    r_b0 <= alu_res[PW-1:0];
                    r_b1 <= r_a1 - jb1;
                    r_b2 <= r_a2 - jb2;
                end
                S_PW_BASE: begin
                    r_base <= alu_res[PW-1:0];
                    r_acc  <= (pm == PW'(1)) ? '0 : PW'(1);
                end
                S_PW_SQ, S_PW_MUL: begin
                    r_acc <= alu_res[PW-1:0];
                end
                S_SMOD: begin
                    if (r_sub[0]) begin
                        r_tq <= smod_fix;
                    end else begin
                        r_sp <= smod_fix;
                    end
                end
                S_CRT: begin
                    if (r_sub[1]) begin
                        r_t2 <= alu_res;
                    end else begin
                        r_t1 <= alu_res;
                    end
                end
                default: begin
                end
            endcase
        end
        if (pw_adv && r_eidx == '0) begin
            if (r_side) begin
                r_v <= alu_res[PW-1:0];
            end else begin
                r_u <= alu_res[PW-1:0];
            end
        end
        if (r_state == S_FIN) begin
            r_ra <= fin_m1;
            r_rc <= fin_m2;
        end
        if (r_state == S_NEG) begin
            r_rb <= (r_ra == '0) ? '0 : r_n - r_ra;
            r_rd <= (r_rc == '0) ? '0 : r_n - r_rc;
        end
    end

    assign o_out.valid  = (r_state == S_OUT);
    assign o_out.root_a = ROOT_W'(r_ra);
    assign o_out.root_b = ROOT_W'(r_rb);
    assign o_out.root_c = ROOT_W'(r_rc);
    assign o_out.root_d = ROOT_W'(r_rd);

    `RED_ASSERT_IMPL(a_done_while_wait, i_clk, i_rst_n, alu_done, r_wait, "alu done without a pending job")
    `RED_ASSERT_NEXT(a_accept_next, i_clk, i_rst_n, in_acc, (r_state == S_CMOD) || (r_state == S_OUT), "bad state after accept")
    `RED_ASSERT_IMPL(a_enc_zero, i_clk, i_rst_n, o_out.valid && (r_op == OP_ENCRYPT), (r_rb == '0) && (r_rc == '0) && (r_rd == '0), "encrypt result with nonzero roots")

endmodule
`default_nettype wire

// File: rtl/rabin_ed_alu.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rabin_encrypt_decrypt_engine_core_assert.svh"
// Bit-serial modular unit: one add-and-reduce per cycle.
//   ALU_MOD   : res = x mod m, quotient bits collected in o_quo
//   ALU_MULMOD: res = a * x mod m (needs a < m), an extra add phase per set bit of x
module rabin_ed_alu
    import rabin_ed_pkg::*;
#(
    parameter int NW = 2 * PRIME_BITS_DEF,
    parameter int QW = PRIME_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_alu_req           i_req,
    input  wire logic [NW-1:0]      i_a,
    input  wire logic [VALUE_W-1:0] i_x,
    input  wire logic [NW-1:0]      i_m,
    output logic                    o_done,
    output logic [NW-1:0]           o_res,
    output logic [QW-1:0]           o_quo
);

    logic                 r_run;
    logic                 r_phase;
    logic                 r_done;
    t_alu_op              r_op;
    logic [ALU_TOP_W-1:0] r_cnt;
    logic [NW-1:0]        r_a;
    logic [VALUE_W-1:0]   r_x;
    logic [NW-1:0]        r_m;
    logic [NW-1:0]        r_r;
    logic [QW-1:0]        r_quo;

    logic          cur_bit;
    logic [NW-1:0] addend;
    logic [NW:0]   sum;
    logic          ge;
    logic [NW-1:0] red;
    logic          bit_end;

    assign cur_bit = r_x[r_cnt];
    assign addend  = (r_op == ALU_MULMOD && r_phase) ? r_a : r_r;
    assign sum     = {1'b0, r_r} + {1'b0, addend}
                     + (NW+1)'((r_op == ALU_MOD) && cur_bit);
    assign ge      = (sum >= {1'b0, r_m});
    assign red     = ge ? NW'(sum - {1'b0, r_m}) : sum[NW-1:0];
    // a multiply bit with a one needs the extra add phase before moving on
    assign bit_end = (r_op == ALU_MOD) || r_phase || !cur_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run   <= 1'b1;
                r_phase <= 1'b0;
            end else if (r_run) begin
                r_phase <= !bit_end;
                if (bit_end && r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= i_req.top;
            r_a   <= i_a;
            r_x   <= i_x;
            r_m   <= i_m;
            r_r   <= '0;
        end else if (r_run) begin
            r_r <= red;
            if (r_op == ALU_MOD) begin
                r_quo <= {r_quo[QW-2:0], ge};
            end
            if (bit_end && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_r;
    assign o_quo  = r_quo;

    `RED_ASSERT_IMPL(a_alu_res_range, i_clk, i_rst_n, r_done, r_r < r_m, "alu result not reduced")
    `RED_ASSERT_IMPL(a_alu_no_restart, i_clk, i_rst_n, i_req.start, !r_run, "alu started while busy")

endmodule
`default_nettype wire
